### sv/ppsu_pkg.sv
// Shared types, widths and helpers for the preemptive priority scheduler.
`timescale 1ns / 1ps

package ppsu_pkg;

  localparam int SLOTS  = 64;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int SLOT_W = 6;
  localparam int TIME_W = 32;
  localparam int ARR_W  = 16;
  localparam int BUR_W  = 16;
  localparam int PRI_W  = 8;
  localparam int IN_W   = 40;
  localparam int OUT_W  = 112;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Best candidate so far, handed from cell to cell.
  typedef struct packed {
    logic             found;
    logic [PRI_W-1:0] pri;
    logic [IDX_W-1:0] idx;
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic [BUR_W-1:0] rem;
  } cand_t;

  // Slot write on a load.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic [PRI_W-1:0] pri;
  } wr_t;

  // Run strobe: the chosen slot consumes one time unit.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } run_t;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] t;
    t = '0;
    t[IDX_W-1:0] = idx;
    return t[SLOT_W-1:0];
  endfunction

endpackage

### sv/ppsu_cell.sv
// One process slot: holds its entry and compares it against the passing candidate.
`timescale 1ns / 1ps

module ppsu_cell
  import ppsu_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  cell_idx,
  input  logic [TIME_W-1:0] now,
  input  logic [CNT_W-1:0]  loaded_count,
  input  wr_t               wr,
  input  run_t              run,
  input  cand_t             cand_i,
  output cand_t             cand_o
);

  logic [ARR_W-1:0] arr_r;
  logic [BUR_W-1:0] bur_r;
  logic [PRI_W-1:0] pri_r;
  logic [BUR_W-1:0] rem_r;
  cand_t            cand_r;
  cand_t            cand_nxt;
  logic             eligible;
  logic             take;

  always_comb begin
    eligible = (CNT_W'(cell_idx) < loaded_count) &&
               ({{(TIME_W-ARR_W){1'b0}}, arr_r} <= now) && (rem_r != '0);
    // strict compare: an earlier slot keeps a tie
    take = eligible && (!cand_i.found || (pri_r < cand_i.pri));
    cand_nxt = cand_i;
    if (take) begin
      cand_nxt.found = 1'b1;
      cand_nxt.pri   = pri_r;
      cand_nxt.idx   = cell_idx;
      cand_nxt.arr   = arr_r;
      cand_nxt.bur   = bur_r;
      cand_nxt.rem   = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    if (wr.en && (wr.idx == cell_idx)) begin
      arr_r <= wr.arr;
      bur_r <= wr.bur;
      pri_r <= wr.pri;
      rem_r <= wr.bur;
    end else if (run.en && (run.idx == cell_idx)) begin
      rem_r <= rem_r - BUR_W'(1);
    end
  end

  assign cand_o = cand_r;

endmodule

### sv/preemptive_priority_scheduler_unit.sv
// Top level: slot chain plus load/tick sequencer and result register.
//
//  channel | dir | handshake          | contents
//  in_     | in  | in_tvalid/tready   | tuser: kind; tdata: arrival, burst, priority_req
//  out_    | out | out_tvalid/tready  | tdata: slot .. all_done, one result per item
//
// A load goes from the transfer straight to S_OUT, which registers the result. On a tick
// the best candidate ripples one slot per cycle down the cell chain, then S_EVAL,
// S_FIN and S_WT choose, compute turnaround and compute waiting.
// One item is in work at a time; a finished result waits in the output register
// while the next item is taken. Synchronous active-low reset clears counters,
// time and control; slot entries are meaningful only below the load count.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_unit
  import ppsu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_tuser,   // [0] kind
  input  logic [IN_W-1:0]  in_tdata,   // [15:0] arrival, [31:16] burst, [39:32] priority_req
  output logic             out_tvalid,
  input  logic             out_tready,
  // [5:0] slot, [6] accepted, [7] idle, [39:8] tick_time, [40] finished,
  // [72:41] turnaround, [104:73] waiting, [105] all_done, [111:106] zero
  output logic [OUT_W-1:0] out_tdata
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EVAL, S_FIN, S_WT, S_OUT} state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  loaded_r;
  logic [CNT_W-1:0]  finished_r;
  logic [TIME_W-1:0] now_r;
  logic [CNT_W-1:0]  cnt_r;
  cand_t             best_r;
  logic              out_tvalid_r;
  logic [OUT_W-1:0]  out_tdata_r;

  logic [SLOT_W-1:0] res_slot_r;
  logic              res_acc_r;
  logic              res_idle_r;
  logic [TIME_W-1:0] res_time_r;
  logic              res_fin_r;
  logic [TIME_W-1:0] res_tat_r;
  logic [TIME_W-1:0] res_wt_r;
  logic              res_done_r;

  cand_t             chain [SLOTS+1];
  wr_t               wr;
  run_t              run;
  logic              accept;
  logic              load_ok;
  logic [ARR_W-1:0]  in_arr;
  logic [BUR_W-1:0]  in_bur;
  logic [PRI_W-1:0]  in_pri;

  assign in_arr = in_tdata[ARR_W-1:0];
  assign in_bur = in_tdata[ARR_W+BUR_W-1:ARR_W];
  assign in_pri = in_tdata[IN_W-1:ARR_W+BUR_W];

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign load_ok    = (loaded_r < CNT_W'(SLOTS)) && (in_bur != '0);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    wr.en  = accept && (in_tuser == KIND_LOAD) && load_ok;
    wr.idx = loaded_r[IDX_W-1:0];
    wr.arr = in_arr;
    wr.bur = in_bur;
    wr.pri = in_pri;
    run.en  = (state_r == S_EVAL) && chain[SLOTS].found;
    run.idx = chain[SLOTS].idx;
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ppsu_cell u_cell (
      .clk          (clk),
      .cell_idx     (IDX_W'(i)),
      .now          (now_r),
      .loaded_count (loaded_r),
      .wr           (wr),
      .run          (run),
      .cand_i       (chain[i]),
      .cand_o       (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      loaded_r     <= '0;
      finished_r   <= '0;
      now_r        <= '0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // S_OUT owns the valid flag while it reloads the output register
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_tuser == KIND_LOAD) begin
              res_idle_r <= 1'b0;
              res_time_r <= '0;
              res_fin_r  <= 1'b0;
              res_tat_r  <= '0;
              res_wt_r   <= '0;
              if (load_ok) begin
                loaded_r   <= loaded_r + CNT_W'(1);
                res_slot_r <= to_slot(loaded_r[IDX_W-1:0]);
                res_acc_r  <= 1'b1;
                res_done_r <= (finished_r == (loaded_r + CNT_W'(1)));
              end else begin
                res_slot_r <= '0;
                res_acc_r  <= 1'b0;
                res_done_r <= (finished_r == loaded_r);
              end
              state_r <= S_OUT;
            end else begin
              cnt_r   <= '0;
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // state is frozen while the candidate fills the chain end to end
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(SLOTS - 1)) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          best_r     <= chain[SLOTS];
          res_acc_r  <= 1'b0;
          res_time_r <= now_r;
          now_r      <= now_r + TIME_W'(1);
          if (chain[SLOTS].found) begin
            res_slot_r <= to_slot(chain[SLOTS].idx);
            res_idle_r <= 1'b0;
            res_fin_r  <= (chain[SLOTS].rem == BUR_W'(1));
            if (chain[SLOTS].rem == BUR_W'(1)) begin
              finished_r <= finished_r + CNT_W'(1);
            end
          end else begin
            res_slot_r <= '0;
            res_idle_r <= 1'b1;
            res_fin_r  <= 1'b0;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          // now_r already holds the completion time
          res_tat_r  <= res_fin_r ? (now_r - {{(TIME_W-ARR_W){1'b0}}, best_r.arr}) : '0;
          res_done_r <= (finished_r == loaded_r);
          state_r    <= S_WT;
        end
        S_WT: begin
          res_wt_r <= res_fin_r ? (res_tat_r - {{(TIME_W-BUR_W){1'b0}}, best_r.bur}) : '0;
          state_r  <= S_OUT;
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {6'b0, res_done_r, res_wt_r, res_tat_r, res_fin_r,
                             res_time_r, res_idle_r, res_acc_r, res_slot_r};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/ppsu_chk.sv
// Port-level checker for the scheduler, bound to the top level.
`timescale 1ns / 1ps

module ppsu_chk
  import ppsu_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             in_tuser,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[6] && out_tdata[7]))
    else $error("result both accepted and idle");

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[40] && out_tdata[7]))
    else $error("idle tick reports a completion");

  a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7] |-> out_tdata[5:0] == '0)
    else $error("idle tick reports a slot");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == KIND_TICK) |=> !in_tready)
    else $error("new transfer taken during a tick scan");

endmodule

bind preemptive_priority_scheduler_unit ppsu_chk u_ppsu_chk (.*);

### dv/tb_preemptive_priority_scheduler_unit.sv
// Self-checking stream testbench for the preemptive priority scheduler unit.
`timescale 1ns / 1ps

import ppsu_pkg::*;

typedef struct packed {
  logic [SLOT_W-1:0] slot;
  logic              accepted;
  logic              idle;
  logic [31:0]       tick_time;
  logic              finished;
  logic [31:0]       turnaround;
  logic [31:0]       waiting;
  logic              all_done;
} sched_result_t;

class sched_scoreboard;
  logic [ARR_W-1:0] arr_tbl [SLOTS];
  logic [BUR_W-1:0] bur_tbl [SLOTS];
  logic [PRI_W-1:0] pri_tbl [SLOTS];
  logic [BUR_W-1:0] rem_tbl [SLOTS];
  int               n_loaded;
  int               n_finished;
  logic [31:0]      now;
  sched_result_t    expected_results [$];
  int               errors;
  int               result_num;

  function new();
    n_loaded   = 0;
    n_finished = 0;
    now        = '0;
    errors     = 0;
    result_num = 0;
  endfunction

  function int loaded();
    return n_loaded;
  endfunction

  function logic [31:0] cur_time();
    return now;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  // Called on every input transfer; queues the result that item should cause.
  function void note_item(logic kind, logic [ARR_W-1:0] a, logic [BUR_W-1:0] b,
                          logic [PRI_W-1:0] p);
    sched_result_t r;
    int            best;
    bit            found;
    logic [31:0]   tat;
    r = '0;
    if (kind == KIND_LOAD) begin
      if (n_loaded < SLOTS && b != '0) begin
        arr_tbl[n_loaded] = a;
        bur_tbl[n_loaded] = b;
        pri_tbl[n_loaded] = p;
        rem_tbl[n_loaded] = b;
        r.slot = SLOT_W'(n_loaded);
        r.accepted = 1'b1;
        n_loaded++;
      end
    end else begin
      found = 0;
      best  = 0;
      for (int i = 0; i < n_loaded; i++) begin
        if ({16'h0, arr_tbl[i]} <= now && rem_tbl[i] != '0) begin
          if (!found || pri_tbl[i] < pri_tbl[best]) begin
            best  = i;
            found = 1;
          end
        end
      end
      r.tick_time = now;
      now = now + 32'd1;
      if (!found) begin
        r.idle = 1'b1;
      end else begin
        r.slot = SLOT_W'(best);
        rem_tbl[best] = rem_tbl[best] - 1'b1;
        if (rem_tbl[best] == '0) begin
          tat = now - {16'h0, arr_tbl[best]};
          r.finished   = 1'b1;
          r.turnaround = tat;
          r.waiting    = tat - {16'h0, bur_tbl[best]};
          n_finished++;
        end
      end
    end
    r.all_done = (n_finished == n_loaded);
    expected_results.push_back(r);
  endfunction

  task report(string msg);
    if (errors < 40) $display("ERROR: %s", msg);
    errors++;
  endtask

  task cmp_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d: %s got 0x%0h, want 0x%0h", result_num, name, got, want));
  endtask

  task check_result(logic [OUT_W-1:0] d);
    sched_result_t e;
    if (expected_results.size() == 0) begin
      report($sformatf("result %0d arrived with none expected: 0x%0h", result_num, d));
    end else begin
      e = expected_results.pop_front();
      cmp_field("slot",       32'(d[5:0]),    32'(e.slot));
      cmp_field("accepted",   32'(d[6]),      32'(e.accepted));
      cmp_field("idle",       32'(d[7]),      32'(e.idle));
      cmp_field("tick_time",  d[39:8],        e.tick_time);
      cmp_field("finished",   32'(d[40]),     32'(e.finished));
      cmp_field("turnaround", d[72:41],       e.turnaround);
      cmp_field("waiting",    d[104:73],      e.waiting);
      cmp_field("all_done",   32'(d[105]),    32'(e.all_done));
      cmp_field("pad",        32'(d[111:106]), 32'd0);
    end
    result_num++;
  endtask
endclass

module tb_preemptive_priority_scheduler_unit;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic             in_tuser   = 1'b0;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  int               gap_pct   = 0;
  int               stall_pct = 0;
  sched_scoreboard  sb;

  preemptive_priority_scheduler_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Present one item, optionally after an idle gap; valid stays high on return.
  task send_item(input logic kind, input logic [ARR_W-1:0] a, input logic [BUR_W-1:0] b,
                 input logic [PRI_W-1:0] p);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < gap_pct) gaps++;
    if (gaps > 0) begin
      in_tvalid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {p, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(kind, a, b, p);
  endtask

  // Tick with random content in the ignored fields.
  task tick_item();
    send_item(KIND_TICK, ARR_W'($urandom), BUR_W'($urandom), PRI_W'($urandom));
  endtask

  task rand_load();
    logic [31:0]      t;
    logic [ARR_W-1:0] a;
    logic [BUR_W-1:0] b;
    logic [PRI_W-1:0] p;
    t = sb.cur_time();
    if ($urandom_range(1)) a = ARR_W'(t + $urandom_range(40));
    else                   a = ARR_W'($urandom_range(t, 0));
    b = ($urandom_range(19) == 0) ? '0 : BUR_W'($urandom_range(12, 1));
    p = $urandom_range(1) ? PRI_W'($urandom) : PRI_W'($urandom_range(3));
    send_item(KIND_LOAD, a, b, p);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, zero burst, preemption, priority tie, all done
    tick_item();
    send_item(KIND_LOAD, 16'd0, 16'd0, 8'd5);
    send_item(KIND_LOAD, 16'd0, 16'd3, 8'd10);
    send_item(KIND_LOAD, 16'd2, 16'd1, 8'd0);
    send_item(KIND_LOAD, 16'd0, 16'd2, 8'd10);
    repeat (8) tick_item();
    send_item(KIND_LOAD, 16'd0, 16'd1, 8'd255);
    tick_item();
    send_item(KIND_LOAD, 16'(sb.cur_time()), 16'd1, 8'd0);
    repeat (2) tick_item();

    // random, four idling phases; leave slots free for the closing part
    for (int i = 0; i < 920; i++) begin
      case ((i * 4) / 920)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 46; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 46; end
        default: begin gap_pct = 21; stall_pct = 21; end
      endcase
      if (sb.loaded() < SLOTS - 8 && $urandom_range(12) == 0) rand_load();
      else tick_item();
    end

    // closing: field extremes, a job that never ends, then a full table
    send_item(KIND_LOAD, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_item(KIND_LOAD, 16'h0000, 16'hFFFF, 8'h00);
    repeat (3) tick_item();
    while (sb.loaded() < SLOTS)
      send_item(KIND_LOAD, ARR_W'($urandom), BUR_W'($urandom_range(16'hFFFF, 1)),
                PRI_W'($urandom));
    repeat (3) rand_load();
    repeat (3) tick_item();
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SLOTS + 20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("preemptive_priority_scheduler_unit test passed");
    end else begin
      $display("preemptive_priority_scheduler_unit test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("preemptive_priority_scheduler_unit test failed");
    $finish;
  end

endmodule

### preemptive_priority_scheduler_unit.f
sv/ppsu_pkg.sv
sv/ppsu_cell.sv
sv/preemptive_priority_scheduler_unit.sv
sv/ppsu_chk.sv
dv/tb_preemptive_priority_scheduler_unit.sv
